>>> hw/rtl/robertson_cct_interpolation_defines.svh
// Assertion macros for the colour temperature block's checker.
// Needs a clock i_clk and an active-low reset i_rst_n in the scope of use.
`ifndef ROBERTSON_CCT_INTERPOLATION_DEFINES_SVH
`define ROBERTSON_CCT_INTERPOLATION_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RCCT_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rcct: same-cycle property violated");

// Consequent must hold in the cycle after the antecedent.
`define RCCT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rcct: next-cycle property violated");

`endif

>>> hw/rtl/rcct_pkg.sv
// Shared types, constants and the isotherm table of the colour temperature block.
// No dependencies.
package rcct_pkg;

    localparam int ROM_ENTRIES         = 31;
    localparam int IDX_W               = $clog2(ROM_ENTRIES);
    localparam int WORK_FRAC           = 24;
    localparam int DEN_LIMIT_BITS      = 40;
    localparam int COORD_W             = 16;
    localparam int DIST_W              = 58;
    localparam int DIV_NUM_W           = 56;
    localparam int DIV_DEN_W           = 40;
    localparam int QUOT_W              = 17;
    localparam int MIRED_W             = 14;
    localparam int DEF_ISOTHERM_COUNT  = 31;
    localparam int DEF_COORD_FRAC_BITS = 16;
    localparam logic [23:0] CCT_SCALE  = 24'd16000000;

    localparam logic [1:0] END_INTERP = 2'd0;
    localparam logic [1:0] END_HOT    = 2'd1;
    localparam logic [1:0] END_COOL   = 2'd2;

    // Isotherms: mired, u and v scaled by 1e5, slope magnitude scaled by 1e5.
    localparam logic [9:0] ISO_MIRED [ROM_ENTRIES] = '{
        10'd0,   10'd10,  10'd20,  10'd30,  10'd40,  10'd50,  10'd60,  10'd70,
        10'd80,  10'd90,  10'd100, 10'd125, 10'd150, 10'd175, 10'd200, 10'd225,
        10'd250, 10'd275, 10'd300, 10'd325, 10'd350, 10'd375, 10'd400, 10'd425,
        10'd450, 10'd475, 10'd500, 10'd525, 10'd550, 10'd575, 10'd600
    };
    localparam logic [16:0] ISO_U5 [ROM_ENTRIES] = '{
        17'd18006, 17'd18066, 17'd18133, 17'd18208, 17'd18293, 17'd18388, 17'd18494,
        17'd18611, 17'd18740, 17'd18880, 17'd19032, 17'd19462, 17'd19962, 17'd20525,
        17'd21142, 17'd21807, 17'd22511, 17'd23247, 17'd24010, 17'd24792, 17'd25591,
        17'd26400, 17'd27218, 17'd28039, 17'd28863, 17'd29685, 17'd30505, 17'd31320,
        17'd32129, 17'd32931, 17'd33724
    };
    localparam logic [16:0] ISO_V5 [ROM_ENTRIES] = '{
        17'd26352, 17'd26589, 17'd26846, 17'd27119, 17'd27407, 17'd27709, 17'd28021,
        17'd28342, 17'd28668, 17'd28997, 17'd29326, 17'd30141, 17'd30921, 17'd31647,
        17'd32312, 17'd32909, 17'd33439, 17'd33904, 17'd34308, 17'd34655, 17'd34951,
        17'd35200, 17'd35407, 17'd35577, 17'd35714, 17'd35823, 17'd35907, 17'd35968,
        17'd36011, 17'd36038, 17'd36051
    };
    localparam logic [23:0] ISO_SLOPE5 [ROM_ENTRIES] = '{
        24'd24341,   24'd25479,   24'd26876,   24'd28539,   24'd30470,   24'd32675,
        24'd35156,   24'd37915,   24'd40955,   24'd44278,   24'd47888,   24'd58204,
        24'd70471,   24'd84901,   24'd101820,  24'd121680,  24'd145120,  24'd172980,
        24'd206370,  24'd246810,  24'd296410,  24'd358140,  24'd436330,  24'd537620,
        24'd672620,  24'd859550,  24'd1132400, 24'd1562800, 24'd2332500, 24'd4077000,
        24'd11645000
    };

    typedef struct packed {
        logic               valid;
        logic [COORD_W-1:0] u;
        logic [COORD_W-1:0] v;
    } t_q_item;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
    } t_div_rsp;

    // Floor of the scaled normal length, evaluated at elaboration only.
    function automatic longint unsigned iso_len(input longint unsigned s);
        longint unsigned x;
        longint unsigned res;
        longint unsigned b;
        x   = (64'd10000000000 + s * s) << 16;
        res = 64'd0;
        b   = 64'd1 << 62;
        for (int k = 0; k < 32; k++) begin
            if (b > x) begin
                b = b >> 2;
            end
        end
        for (int k = 0; k < 32; k++) begin
            if (b != 64'd0) begin
                if (x >= res + b) begin
                    x   = x - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
        end
        return res;
    endfunction

    // Dividend of the kelvin conversion, rounding half up.
    function automatic logic [DIV_NUM_W-1:0] cct_num(input logic [MIRED_W-1:0] mx);
        return DIV_NUM_W'(CCT_SCALE) + DIV_NUM_W'(mx >> 1);
    endfunction

endpackage

>>> hw/rtl/robertson_cct_interpolation.sv
// Sequence: the engine examines up to 30 isotherms, each in states S_MUL and S_CMP, then
// normalises, interpolates and runs the mired and the kelvin divisions; end cases
// skip interpolation and the mired division. The engine takes no new transaction before
// it is through with the last, as the isotherm step and the bit-serial divider are not
// pipelined; a two-deep queue takes up to two further transactions meanwhile.
// Reset: synchronous, active low; clears the queue, the sequencer and the result strobe.
module robertson_cct_interpolation #(
    parameter int ISOTHERM_COUNT  = rcct_pkg::DEF_ISOTHERM_COUNT,
    parameter int COORD_FRAC_BITS = rcct_pkg::DEF_COORD_FRAC_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [rcct_pkg::COORD_W-1:0] i_u_coord,
    input  logic [rcct_pkg::COORD_W-1:0] i_v_coord,
    output logic                         o_strobe,
    output logic [rcct_pkg::QUOT_W-1:0]  o_cct_kelvin,
    output logic [rcct_pkg::MIRED_W-1:0] o_mired_x16,
    output logic [1:0]                   o_end_case
);
    import rcct_pkg::*;

    // The front end takes a transaction whenever its queue has room, so a new
    // chromaticity can be handed over while the engine is still walking the table.
    t_q_item w_item;
    logic    w_pop;

    rcct_front #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .i_u     (i_u_coord),
        .i_v     (i_v_coord),
        .o_item  (w_item),
        .i_pop   (w_pop)
    );

    // The engine walks the isotherms from index 1 until the signed distance is not positive
    // or the last is reached, interpolates the reciprocal temperature except in end cases
    // and converts it to kelvin. Each result is shown for a single cycle with o_strobe high.
    rcct_engine #(
        .ISOTHERM_COUNT  (ISOTHERM_COUNT),
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (w_item),
        .o_pop        (w_pop),
        .o_strobe     (o_strobe),
        .o_cct_kelvin (o_cct_kelvin),
        .o_mired_x16  (o_mired_x16),
        .o_end_case   (o_end_case)
    );

endmodule

>>> hw/rtl/rcct_front.sv
// Front end: takes transactions, masks the coordinates and queues them (two deep).
// Depends on rcct_pkg.
module rcct_front #(
    parameter int COORD_FRAC_BITS = rcct_pkg::DEF_COORD_FRAC_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    output logic                        o_busy,
    input  logic [rcct_pkg::COORD_W-1:0] i_u,
    input  logic [rcct_pkg::COORD_W-1:0] i_v,
    output rcct_pkg::t_q_item           o_item,
    input  logic                        i_pop
);
    import rcct_pkg::*;

    localparam int KEEP = (COORD_FRAC_BITS < COORD_W) ? COORD_FRAC_BITS : COORD_W;
    localparam logic [COORD_W-1:0] MASK = COORD_W'((33'd1 << KEEP) - 33'd1);

    logic [COORD_W-1:0] r_u [2];
    logic [COORD_W-1:0] r_v [2];
    logic               r_wr, r_rd;
    logic [1:0]         r_cnt;
    logic               w_push, w_pop;

    assign o_busy = (r_cnt == 2'd2);
    assign w_push = i_start && !o_busy;
    assign w_pop  = i_pop && (r_cnt != 2'd0);

    assign o_item.valid = (r_cnt != 2'd0);
    assign o_item.u     = r_u[r_rd];
    assign o_item.v     = r_v[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr <= ~r_wr;
            end
            if (w_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_u[r_wr] <= i_u & MASK;
            r_v[r_wr] <= i_v & MASK;
        end
    end

endmodule

>>> hw/rtl/rcct_div.sv
// Restoring divider, one quotient bit per cycle, shared by both divisions.
// Depends on rcct_pkg.
module rcct_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rcct_pkg::t_div_req i_req,
    output rcct_pkg::t_div_rsp o_rsp
);
    import rcct_pkg::*;

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [4:0]           r_k, n_k;
    logic [DIV_NUM_W-1:0] r_rem, n_rem;
    logic [DIV_NUM_W-1:0] r_dsh, n_dsh;
    logic [QUOT_W-1:0]    r_quot, n_quot;
    logic [DIV_NUM_W:0]   w_trial;

    assign w_trial    = {1'b0, r_rem} - {1'b0, r_dsh};
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_k    = r_k;
        n_rem  = r_rem;
        n_dsh  = r_dsh;
        n_quot = r_quot;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_k    = 5'(QUOT_W - 1);
            n_rem  = i_req.num;
            n_dsh  = DIV_NUM_W'(i_req.den) << (QUOT_W - 1);
            n_quot = '0;
        end else if (r_busy) begin
            if (!w_trial[DIV_NUM_W]) begin
                n_rem  = w_trial[DIV_NUM_W-1:0];
                n_quot = {r_quot[QUOT_W-2:0], 1'b1};
            end else begin
                n_quot = {r_quot[QUOT_W-2:0], 1'b0};
            end
            n_dsh = r_dsh >> 1;
            if (r_k == 5'd0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_k = r_k - 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_k    <= n_k;
        r_rem  <= n_rem;
        r_dsh  <= n_dsh;
        r_quot <= n_quot;
    end

endmodule

>>> hw/rtl/rcct_engine.sv
// Back end: isotherm walk, normalisation, interpolation and the two divisions.
// Depends on rcct_pkg and rcct_div.
module rcct_engine #(
    parameter int ISOTHERM_COUNT  = rcct_pkg::DEF_ISOTHERM_COUNT,
    parameter int COORD_FRAC_BITS = rcct_pkg::DEF_COORD_FRAC_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  rcct_pkg::t_q_item            i_item,
    output logic                         o_pop,
    output logic                         o_strobe,
    output logic [rcct_pkg::QUOT_W-1:0]  o_cct_kelvin,
    output logic [rcct_pkg::MIRED_W-1:0] o_mired_x16,
    output logic [1:0]                   o_end_case
);
    import rcct_pkg::*;

    localparam int SHIFT = WORK_FRAC - COORD_FRAC_BITS;
    localparam int LIVE  = (ISOTHERM_COUNT < 2) ? 2 :
                           ((ISOTHERM_COUNT > ROM_ENTRIES) ? ROM_ENTRIES : ISOTHERM_COUNT);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LIVE - 1);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_MUL  = 8'b0000_0010,
        S_CMP  = 8'b0000_0100,
        S_NORM = 8'b0000_1000,
        S_NUM1 = 8'b0001_0000,
        S_NUM2 = 8'b0010_0000,
        S_DIVM = 8'b0100_0000,
        S_DIVK = 8'b1000_0000
    } t_state;

    // Isotherm constants, derived per entry at elaboration.
    logic [30:0]        w_du_t    [ROM_ENTRIES];
    logic [30:0]        w_dvm_t   [ROM_ENTRIES];
    logic [23:0]        w_uq_t    [ROM_ENTRIES];
    logic [23:0]        w_vq_t    [ROM_ENTRIES];
    logic [MIRED_W-1:0] w_mired_t [ROM_ENTRIES];

    for (genvar g = 0; g < ROM_ENTRIES; g++) begin : g_rom
        localparam longint unsigned S   = 64'(ISO_SLOPE5[g]);
        localparam longint unsigned L   = iso_len(S);
        localparam longint unsigned DU  = ((64'd100000 << 38) + L / 2) / L;
        localparam longint unsigned DVM = ((S << 38) + L / 2) / L;
        localparam longint unsigned UQ  = ((64'(ISO_U5[g]) << WORK_FRAC) + 64'd50000) / 100000;
        localparam longint unsigned VQ  = ((64'(ISO_V5[g]) << WORK_FRAC) + 64'd50000) / 100000;
        assign w_du_t[g]    = 31'(DU);
        assign w_dvm_t[g]   = 31'(DVM);
        assign w_uq_t[g]    = 24'(UQ);
        assign w_vq_t[g]    = 24'(VQ);
        assign w_mired_t[g] = MIRED_W'({ISO_MIRED[g], 4'd0});
    end

    t_state               r_state, n_state;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic [COORD_W-1:0]   r_u, n_u, r_v, n_v;
    logic signed [DIST_W-1:0] r_pu, n_pu, r_pv, n_pv;
    logic [DIST_W-2:0]    r_dp, n_dp, r_dc, n_dc;
    logic [DIV_NUM_W-1:0] r_num, n_num;
    logic [MIRED_W-1:0]   r_mx, n_mx;
    logic [1:0]           r_ecase, n_ecase;
    logic [QUOT_W-1:0]    r_cct, n_cct;
    logic                 r_strobe, n_strobe;
    t_div_req             r_req, n_req;
    t_div_rsp             w_rsp;

    logic [24:0]              w_uq, w_vq;
    logic signed [25:0]       w_uoff, w_voff;
    logic signed [DIST_W-1:0] w_dist;
    logic [DIST_W-1:0]        w_sum;
    logic [MIRED_W-1:0]       w_mcur, w_mprev;

    assign w_uq    = 25'({9'd0, r_u} << SHIFT);
    assign w_vq    = 25'({9'd0, r_v} << SHIFT);
    assign w_uoff  = $signed({1'b0, w_uq}) - $signed({2'b0, w_uq_t[r_idx]});
    assign w_voff  = $signed({1'b0, w_vq}) - $signed({2'b0, w_vq_t[r_idx]});
    assign w_dist  = r_pu + r_pv;
    assign w_sum   = {1'b0, r_dp} + {1'b0, r_dc};
    assign w_mcur  = w_mired_t[r_idx];
    assign w_mprev = w_mired_t[r_idx - IDX_W'(1)];

    rcct_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_req),
        .o_rsp   (w_rsp)
    );

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_u       = r_u;
        n_v       = r_v;
        n_pu      = r_pu;
        n_pv      = r_pv;
        n_dp      = r_dp;
        n_dc      = r_dc;
        n_num     = r_num;
        n_mx      = r_mx;
        n_ecase   = r_ecase;
        n_cct     = r_cct;
        n_strobe  = 1'b0;
        n_req     = r_req;
        n_req.start = 1'b0;
        o_pop     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_item.valid) begin
                    o_pop   = 1'b1;
                    n_u     = i_item.u;
                    n_v     = i_item.v;
                    n_idx   = IDX_W'(1);
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_pu    = DIST_W'(w_uoff) * DIST_W'($signed({1'b0, w_dvm_t[r_idx]}));
                n_pv    = DIST_W'(w_voff) * DIST_W'($signed({1'b0, w_du_t[r_idx]}));
                n_state = S_CMP;
            end
            S_CMP: begin
                if (w_dist <= 0) begin
                    if (r_idx == IDX_W'(1)) begin
                        n_mx        = w_mired_t[1];
                        n_ecase     = END_HOT;
                        n_req.start = 1'b1;
                        n_req.num   = cct_num(w_mired_t[1]);
                        n_req.den   = DIV_DEN_W'(w_mired_t[1]);
                        n_state     = S_DIVK;
                    end else begin
                        n_dc    = (DIST_W-1)'(-w_dist);
                        n_ecase = END_INTERP;
                        n_state = S_NORM;
                    end
                end else begin
                    n_dp = (DIST_W-1)'(w_dist);
                    if (r_idx == LAST_IDX) begin
                        n_mx        = w_mired_t[LAST_IDX];
                        n_ecase     = END_COOL;
                        n_req.start = 1'b1;
                        n_req.num   = cct_num(w_mired_t[LAST_IDX]);
                        n_req.den   = DIV_DEN_W'(w_mired_t[LAST_IDX]);
                        n_state     = S_DIVK;
                    end else begin
                        n_idx   = r_idx + IDX_W'(1);
                        n_state = S_MUL;
                    end
                end
            end
            S_NORM: begin
                if (|w_sum[DIST_W-1:DEN_LIMIT_BITS]) begin
                    n_dp = r_dp >> 1;
                    n_dc = r_dc >> 1;
                end else begin
                    n_state = S_NUM1;
                end
            end
            S_NUM1: begin
                n_num   = DIV_NUM_W'(w_mcur) * DIV_NUM_W'(r_dp[DEN_LIMIT_BITS-1:0]);
                n_state = S_NUM2;
            end
            S_NUM2: begin
                n_req.start = 1'b1;
                n_req.num   = r_num
                            + DIV_NUM_W'(w_mprev) * DIV_NUM_W'(r_dc[DEN_LIMIT_BITS-1:0])
                            + DIV_NUM_W'(w_sum[DEN_LIMIT_BITS-1:1]);
                n_req.den   = w_sum[DIV_DEN_W-1:0];
                n_state     = S_DIVM;
            end
            S_DIVM: begin
                if (w_rsp.done) begin
                    n_mx        = w_rsp.quot[MIRED_W-1:0];
                    n_req.start = 1'b1;
                    n_req.num   = cct_num(w_rsp.quot[MIRED_W-1:0]);
                    n_req.den   = DIV_DEN_W'(w_rsp.quot[MIRED_W-1:0]);
                    n_state     = S_DIVK;
                end
            end
            S_DIVK: begin
                if (w_rsp.done) begin
                    n_cct    = w_rsp.quot;
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_strobe    <= 1'b0;
            r_req.start <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_strobe    <= n_strobe;
            r_req.start <= n_req.start;
        end
        r_idx     <= n_idx;
        r_u       <= n_u;
        r_v       <= n_v;
        r_pu      <= n_pu;
        r_pv      <= n_pv;
        r_dp      <= n_dp;
        r_dc      <= n_dc;
        r_num     <= n_num;
        r_mx      <= n_mx;
        r_ecase   <= n_ecase;
        r_cct     <= n_cct;
        r_req.num <= n_req.num;
        r_req.den <= n_req.den;
    end

    assign o_strobe     = r_strobe;
    assign o_cct_kelvin = r_cct;
    assign o_mired_x16  = r_mx;
    assign o_end_case   = r_ecase;

endmodule

>>> hw/rtl/rcct_checker.sv
// Port-level checker for the colour temperature block, bound to the top level.
// Depends on rcct_pkg and robertson_cct_interpolation_defines.svh.
`include "robertson_cct_interpolation_defines.svh"

module rcct_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_strobe,
    input logic [rcct_pkg::QUOT_W-1:0]  o_cct_kelvin,
    input logic [rcct_pkg::MIRED_W-1:0] o_mired_x16,
    input logic [1:0]                   o_end_case
);
    import rcct_pkg::*;

    `RCCT_ASSERT_SAME(a_case_code, o_strobe, (o_end_case == END_INTERP) || (o_end_case == END_HOT) || (o_end_case == END_COOL))
    `RCCT_ASSERT_SAME(a_hot_end, o_strobe && (o_end_case == END_HOT), (o_mired_x16 == 14'd160) && (o_cct_kelvin == 17'd100000))
    `RCCT_ASSERT_SAME(a_mired_span, o_strobe, (o_mired_x16 >= 14'd160) && (o_mired_x16 <= 14'd9600))
    `RCCT_ASSERT_NEXT(a_single_strobe, o_strobe, !o_strobe)

endmodule

bind robertson_cct_interpolation rcct_checker u_rcct_checker (.*);

>>> sim/rcct_checker.sv
`timescale 1ns / 100ps
// Checker for the colour temperature block: predicts each result and compares it.
// Depends on rcct_pkg for the isotherm table and the end-case codes.
module rcct_scoreboard (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    input  logic                         busy,
    input  logic [rcct_pkg::COORD_W-1:0] i_u_coord,
    input  logic [rcct_pkg::COORD_W-1:0] i_v_coord,
    input  logic                         o_strobe,
    input  logic [rcct_pkg::QUOT_W-1:0]  o_cct_kelvin,
    input  logic [rcct_pkg::MIRED_W-1:0] o_mired_x16,
    input  logic [1:0]                   o_end_case,
    output int                           o_fail_count,
    output int                           o_pending
);
    import rcct_pkg::*;

    typedef struct packed {
        logic [QUOT_W-1:0]  kelvin;
        logic [MIRED_W-1:0] mired;
        logic [1:0]         ecase;
    } t_cct_result;

    longint      iso_du [ROM_ENTRIES];
    longint      iso_dvm [ROM_ENTRIES];
    longint      iso_uq [ROM_ENTRIES];
    longint      iso_vq [ROM_ENTRIES];
    t_cct_result cct_expected [$];

    function automatic longint unsigned floor_sqrt(input longint unsigned x);
        longint unsigned r;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= x) begin
                r = r | (64'd1 << b);
            end
        end
        return r;
    endfunction

    initial begin
        longint unsigned s;
        longint unsigned len;
        for (int i = 0; i < ROM_ENTRIES; i++) begin
            s          = ISO_SLOPE5[i];
            len        = floor_sqrt((64'd10000000000 + s * s) << 16);
            iso_du[i]  = ((64'd100000 << 38) + len / 2) / len;
            iso_dvm[i] = ((s << 38) + len / 2) / len;
            iso_uq[i]  = ((longint'(ISO_U5[i]) << WORK_FRAC) + 50000) / 100000;
            iso_vq[i]  = ((longint'(ISO_V5[i]) << WORK_FRAC) + 50000) / 100000;
        end
    end

    function automatic longint iso_dist(input int i, input longint uq, input longint vq);
        return (uq - iso_uq[i]) * iso_dvm[i] + (vq - iso_vq[i]) * iso_du[i];
    endfunction

    function automatic t_cct_result predict_cct(input logic [15:0] u, input logic [15:0] v);
        t_cct_result     r;
        longint          uq;
        longint          vq;
        longint          dcur;
        longint          dp;
        longint          dc;
        longint unsigned num;
        longint unsigned den;
        longint unsigned mx;
        int              idx;
        uq  = longint'(u) << (WORK_FRAC - DEF_COORD_FRAC_BITS);
        vq  = longint'(v) << (WORK_FRAC - DEF_COORD_FRAC_BITS);
        idx = 0;
        for (int i = 1; i < ROM_ENTRIES; i++) begin
            dcur = iso_dist(i, uq, vq);
            if (dcur <= 0) begin
                idx = i;
                break;
            end
        end
        if (idx == 1) begin
            mx      = 16 * ISO_MIRED[1];
            r.ecase = END_HOT;
        end else if (idx == 0) begin
            mx      = 16 * ISO_MIRED[ROM_ENTRIES-1];
            r.ecase = END_COOL;
        end else begin
            dp = iso_dist(idx - 1, uq, vq);
            dc = -dcur;
            while (dp + dc >= (64'sd1 << DEN_LIMIT_BITS)) begin
                dp = dp >>> 1;
                dc = dc >>> 1;
            end
            den     = dp + dc;
            num     = 16 * ISO_MIRED[idx] * dp + 16 * ISO_MIRED[idx-1] * dc;
            mx      = (num + den / 2) / den;
            r.ecase = END_INTERP;
        end
        r.kelvin = QUOT_W'((64'd16000000 + mx / 2) / mx);
        r.mired  = mx[MIRED_W-1:0];
        return r;
    endfunction

    assign o_pending = cct_expected.size();

    // Inputs are sampled on the edge itself, before the block updates its outputs.
    always @(posedge i_clk) begin
        t_cct_result want;
        if (!i_rst_n) begin
            o_fail_count <= 0;
        end else begin
            if (start && !busy) begin
                cct_expected = {cct_expected, predict_cct(i_u_coord, i_v_coord)};
            end
            if (o_strobe) begin
                if (cct_expected.size() == 0) begin
                    $display("%0t: result with none expected: kelvin %0d mired_x16 %0d end %0d",
                             $time, o_cct_kelvin, o_mired_x16, o_end_case);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = cct_expected.pop_front();
                    if (want.kelvin !== o_cct_kelvin || want.mired !== o_mired_x16 ||
                        want.ecase !== o_end_case) begin
                        $display({"%0t: kelvin exp %0d got %0d, ",
                                  "mired_x16 exp %0d got %0d, end exp %0d got %0d"},
                                 $time, want.kelvin, o_cct_kelvin, want.mired, o_mired_x16,
                                 want.ecase, o_end_case);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

>>> sim/tb_robertson_cct_interpolation.sv
`timescale 1ns / 100ps
// Top of the colour temperature testbench: clock, reset, stimulus and the verdict.
// Depends on rcct_pkg, the block itself and rcct_scoreboard.
module tb_robertson_cct_interpolation;
    import rcct_pkg::*;

    localparam int RANDOM_ITEMS = 1050;
    localparam int CALM_ITEMS   = 150;
    localparam int CYCLE_LIMIT  = 2000000;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [COORD_W-1:0] i_u_coord;
    logic [COORD_W-1:0] i_v_coord;
    logic               o_strobe;
    logic [QUOT_W-1:0]  o_cct_kelvin;
    logic [MIRED_W-1:0] o_mired_x16;
    logic [1:0]         o_end_case;
    int                 fail_count;
    int                 pending;
    int                 cycle_count;

    robertson_cct_interpolation dut (.*);

    rcct_scoreboard checker_inst (
        .i_clk, .i_rst_n, .start, .busy, .i_u_coord, .i_v_coord,
        .o_strobe, .o_cct_kelvin, .o_mired_x16, .o_end_case,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The watchdog: it ends the run with a failure once the cycle count passes CYCLE_LIMIT.
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Converts an isotherm coordinate (scaled by 1e5) into the Q0.16 input format.
    function automatic logic [15:0] locus_q16(input logic [16:0] x5);
        return 16'((longint'(x5) * 65536 + 50000) / 100000);
    endfunction

    // Presents one transaction and holds it until the block accepts it. Start is
    // left high, so that back-to-back transactions keep it up without a glitch.
    task automatic send_chroma(input logic [15:0] u, input logic [15:0] v, input bit idle_ok);
        int gap;
        if (idle_ok && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 14);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start     <= 1'b1;
        i_u_coord <= u;
        i_v_coord <= v;
        do @(posedge i_clk); while (busy);
    endtask

    // A point near a randomly chosen isotherm, which is where the crossings lie.
    task automatic send_near_locus(input bit idle_ok);
        int k;
        int du;
        int dv;
        k  = $urandom_range(0, ROM_ENTRIES - 1);
        du = int'($urandom_range(0, 1600)) - 800;
        dv = int'($urandom_range(0, 1600)) - 800;
        send_chroma(16'(int'(locus_q16(ISO_U5[k])) + du),
                    16'(int'(locus_q16(ISO_V5[k])) + dv), idle_ok);
    endtask

    initial begin
        int wait_cycles;
        start     <= 1'b0;
        i_u_coord <= '0;
        i_v_coord <= '0;
        i_rst_n   <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: the corners of the input range, which give the hot end
        // and the no-crossing end, then points on the first, last and some middle
        // isotherms, so that crossings at index one and at the last entry occur.
        send_chroma(16'h0000, 16'h0000, 1'b0);
        send_chroma(16'hFFFF, 16'hFFFF, 1'b0);
        send_chroma(16'h0000, 16'hFFFF, 1'b0);
        send_chroma(16'hFFFF, 16'h0000, 1'b0);
        send_chroma(16'hAAAA, 16'h5555, 1'b0);
        send_chroma(16'h5555, 16'hAAAA, 1'b0);
        foreach (ISO_U5[k]) begin
            if (k < 3 || k > ROM_ENTRIES - 4 || k % 5 == 0) begin
                send_chroma(locus_q16(ISO_U5[k]), locus_q16(ISO_V5[k]), 1'b0);
            end
        end
        send_chroma(locus_q16(ISO_U5[ROM_ENTRIES-1]) + 16'd400,
                    locus_q16(ISO_V5[ROM_ENTRIES-1]), 1'b0);

        // Random part: mostly points near the locus, the rest anywhere. The last
        // stretch runs without idle gaps to check back-to-back transactions.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if ($urandom_range(0, 9) < 7) begin
                send_near_locus(n < RANDOM_ITEMS - CALM_ITEMS);
            end else begin
                send_chroma(16'($urandom), 16'($urandom), n < RANDOM_ITEMS - CALM_ITEMS);
            end
        end
        start <= 1'b0;

        // Drain: every expected result must come within a bounded time.
        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 5000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (200) @(posedge i_clk);
        if (pending == 0 && fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
